FILE: sv/assert_macros.svh
// Assertion macros used by the top-level blender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: sv/rgbao_pkg.sv
// ----------------------------------------------------------------------------
// rgbao_pkg
// Types, constants and the cell data record for the alpha-over blender.
// ----------------------------------------------------------------------------
`default_nettype none
package rgbao_pkg;
    localparam int unsigned NumCells = 8;   // bits of the color quotient
    localparam logic [7:0]  Max8     = 8'd255;
    localparam logic [8:0]  Half     = 9'd127;

    typedef struct packed {
        logic [7:0] front_red;
        logic [7:0] front_green;
        logic [7:0] front_blue;
        logic [7:0] front_alpha;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
        logic [7:0] back_alpha;
    } t_in;

    typedef struct packed {
        logic [7:0] result_red;
        logic [7:0] result_green;
        logic [7:0] result_blue;
        logic [7:0] result_alpha;
    } t_out;

    // One restoring-division channel: partial remainder and quotient so far.
    typedef struct packed {
        logic [16:0] rem;
        logic [7:0]  quo;
    } t_chan;

    // Record handed from cell to cell.
    typedef struct packed {
        logic       valid;
        logic       pass;
        t_chan [2:0] ch;
        logic [7:0] oa;
        t_out       bypass;
    } t_cell;
endpackage
`default_nettype wire

FILE: sv/rgba_alpha_over_blend.sv
// ----------------------------------------------------------------------------
// rgba_alpha_over_blend
// Straight-alpha 8-bit RGBA "over" compositor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one front and one back pixel per
//   transaction; output channel o_valid/i_stall returns the blended pixel.
//   A pixel is accepted on every cycle the pipeline can advance, so the
//   sustained rate is one pixel per clock.
//   Products and dividends are formed in the front end, which is followed by
//   a row of eight cells that each resolve one quotient bit of the three
//   color divisions by the result alpha, MSB first.
//   When the receiver stalls, the whole row holds; o_stall is raised while
//   the last stage holds a result that cannot leave, and bubbles inside the
//   row are not squeezed out during that time.
//   Reset clears all valid flags; no pixel is in flight afterwards.
//   A transparent front pixel passes the back pixel unchanged.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rgba_alpha_over_blend (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire rgbao_pkg::t_in   i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output rgbao_pkg::t_out       o_data
);
    logic             w_en;
    rgbao_pkg::t_cell w_row [rgbao_pkg::NumCells:0];
    rgbao_pkg::t_cell w_last;
    logic             w_rem_ok;

    assign w_last   = w_row[rgbao_pkg::NumCells];
    assign w_rem_ok = w_last.ch[0].rem < 17'(w_last.oa);

    // Advance unless the final stage holds a result the receiver refuses.
    assign w_en    = !(w_last.valid && i_stall);
    assign o_stall = !w_en;

    rgbao_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_pix   (i_data),
        .o_cell  (w_row[0])
    );

    for (genvar g = 0; g < rgbao_pkg::NumCells; g++) begin : g_cell
        rgbao_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bit   (3'(rgbao_pkg::NumCells - 1 - g)),
            .i_cell  (w_row[g]),
            .o_cell  (w_row[g+1])
        );
    end

    always_comb begin
        if (w_last.pass) begin
            o_data = w_last.bypass;
        end else begin
            o_data.result_red   = w_last.ch[0].quo;
            o_data.result_green = w_last.ch[1].quo;
            o_data.result_blue  = w_last.ch[2].quo;
            o_data.result_alpha = w_last.oa;
        end
    end
    assign o_valid = w_last.valid;

    `ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `ASSERT_IMPLIES(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `ASSERT_IMPLIES(a_rem_below_den, i_clk, i_rst_n, o_valid && !w_last.pass, w_rem_ok)
endmodule
`default_nettype wire

FILE: sv/rgbao_prep.sv
// ----------------------------------------------------------------------------
// rgbao_prep
// Two-stage front end: products, then result alpha and channel dividends.
// ----------------------------------------------------------------------------
`default_nettype none
module rgbao_prep (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire rgbao_pkg::t_in  i_pix,
    output rgbao_pkg::t_cell     o_cell
);
    logic            r_v1;
    rgbao_pkg::t_in  r_p1;
    logic [7:0]      r_inv;
    logic [15:0]     r_ba_inv;
    logic [15:0]     r_bcba [2:0];
    logic [15:0]     r_fcfa [2:0];
    logic [7:0]      w_fc [2:0];
    logic [7:0]      w_bc [2:0];
    logic [7:0]      w_inv;
    logic [16:0]     w_sum_a;
    logic [23:0]     w_trip [2:0];
    rgbao_pkg::t_cell n_cell;
    rgbao_pkg::t_cell r_cell;

    // Floor of x / 255 as x * 0x01010102 >> 32, exact for x below 2^32 / 254.
    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [49:0] acc;
        acc = ({26'd0, x} << 24) + ({26'd0, x} << 16) + ({26'd0, x} << 8)
            + ({26'd0, x} << 1);
        return acc[47:32];
    endfunction

    assign w_fc[0] = i_pix.front_red;
    assign w_fc[1] = i_pix.front_green;
    assign w_fc[2] = i_pix.front_blue;
    assign w_bc[0] = i_pix.back_red;
    assign w_bc[1] = i_pix.back_green;
    assign w_bc[2] = i_pix.back_blue;
    assign w_inv   = rgbao_pkg::Max8 - i_pix.front_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_p1     <= i_pix;
            r_inv    <= w_inv;
            r_ba_inv <= 16'(i_pix.back_alpha * w_inv);
            for (int k = 0; k < 3; k++) begin
                r_bcba[k] <= 16'(w_bc[k] * i_pix.back_alpha);
                r_fcfa[k] <= 16'(w_fc[k] * i_pix.front_alpha);
            end
        end
    end

    always_comb begin
        w_sum_a = 17'(r_ba_inv) + 17'(rgbao_pkg::Half);
        n_cell = '0;
        n_cell.valid = r_v1;
        n_cell.pass  = (r_p1.front_alpha == 8'd0);
        n_cell.oa    = 8'(r_p1.front_alpha + div255({7'd0, w_sum_a})[7:0]);
        n_cell.bypass.result_red   = r_p1.back_red;
        n_cell.bypass.result_green = r_p1.back_green;
        n_cell.bypass.result_blue  = r_p1.back_blue;
        n_cell.bypass.result_alpha = r_p1.back_alpha;
        for (int k = 0; k < 3; k++) begin
            w_trip[k] = 24'(r_bcba[k] * r_inv);
            n_cell.ch[k].rem = 17'(r_fcfa[k]) + 17'(div255(w_trip[k]));
            n_cell.ch[k].quo = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.pass   <= n_cell.pass;
            r_cell.ch     <= n_cell.ch;
            r_cell.oa     <= n_cell.oa;
            r_cell.bypass <= n_cell.bypass;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

FILE: sv/rgbao_cell.sv
// ----------------------------------------------------------------------------
// rgbao_cell
// One restoring-division step for three channels by the result alpha.
// ----------------------------------------------------------------------------
`default_nettype none
module rgbao_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [2:0]        i_bit,
    input  wire rgbao_pkg::t_cell  i_cell,
    output rgbao_pkg::t_cell       o_cell
);
    rgbao_pkg::t_cell n_cell;
    rgbao_pkg::t_cell r_cell;
    logic [16:0]      w_den [2:0];

    always_comb begin
        n_cell = i_cell;
        for (int k = 0; k < 3; k++) begin
            w_den[k] = 17'(i_cell.oa) << i_bit;
            if (i_cell.ch[k].rem >= w_den[k]) begin
                n_cell.ch[k].rem = i_cell.ch[k].rem - w_den[k];
                n_cell.ch[k].quo[i_bit] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.pass   <= n_cell.pass;
            r_cell.ch     <= n_cell.ch;
            r_cell.oa     <= n_cell.oa;
            r_cell.bypass <= n_cell.bypass;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire
